// ----- src/bdq_pkg.sv -----
`default_nettype none

package bdq_pkg;

    localparam int DEPTH  = 16;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int OCC_W  = 5;
    localparam int CMD_W  = 3;

    localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_REAR  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_REAR   = 3'd3,
        CMD_PEEK       = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [WORD_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic                     error;
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] rear_value;
        logic                     is_empty;
        logic                     is_full;
        logic [OCC_W-1:0]         occupancy;
    } t_out;

    // write request from the pointer logic to the entry memory
    typedef struct packed {
        logic          en;
        logic [AW-1:0] addr;
    } t_wr;

    // queue status after the last command
    typedef struct packed {
        logic [AW-1:0] head;
        logic [AW-1:0] rear;
        logic [CW-1:0] count;
        logic          err;
        logic          empty;
        logic          full;
    } t_stat;

endpackage

`default_nettype wire

// ----- src/bdq_ram.sv -----
`default_nettype none

module bdq_ram (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [bdq_pkg::AW-1:0]      i_waddr,
    input  wire logic [bdq_pkg::WORD_W-1:0]  i_wdata,
    input  wire logic                        i_re,
    input  wire logic [bdq_pkg::AW-1:0]      i_raddr_a,
    input  wire logic [bdq_pkg::AW-1:0]      i_raddr_b,
    output logic      [bdq_pkg::WORD_W-1:0]  o_rdata_a,
    output logic      [bdq_pkg::WORD_W-1:0]  o_rdata_b
);

    logic [bdq_pkg::WORD_W-1:0] r_mem [bdq_pkg::DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

// ----- src/bdq_ptr.sv -----
`default_nettype none

module bdq_ptr (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_go,
    input  wire logic [bdq_pkg::CMD_W-1:0]  i_cmd,
    output bdq_pkg::t_wr                    o_wr,
    output bdq_pkg::t_stat                  o_stat
);

    localparam int SW = bdq_pkg::AW + 2;

    logic [bdq_pkg::AW-1:0] r_head, n_head;
    logic [bdq_pkg::CW-1:0] r_count, n_count;
    logic                   r_err, n_err;

    logic                   full, empty;
    logic [bdq_pkg::AW-1:0] head_dec, head_inc, tail_slot, rear_slot;
    logic [SW-1:0]          tail_sum, rear_sum;

    assign full  = (r_count == bdq_pkg::CW'(bdq_pkg::DEPTH));
    assign empty = (r_count == '0);

    assign head_dec = (r_head == '0) ? bdq_pkg::AW'(bdq_pkg::DEPTH - 1) : r_head - 1'b1;
    assign head_inc = (r_head == bdq_pkg::AW'(bdq_pkg::DEPTH - 1)) ? '0 : r_head + 1'b1;

    // wrap once: head plus count stays below twice the depth
    assign tail_sum  = SW'(r_head) + SW'(r_count);
    assign tail_slot = (tail_sum >= SW'(bdq_pkg::DEPTH)) ?
                       bdq_pkg::AW'(tail_sum - SW'(bdq_pkg::DEPTH)) : bdq_pkg::AW'(tail_sum);
    assign rear_sum  = tail_sum - SW'(1);
    assign rear_slot = (rear_sum >= SW'(bdq_pkg::DEPTH)) ?
                       bdq_pkg::AW'(rear_sum - SW'(bdq_pkg::DEPTH)) : bdq_pkg::AW'(rear_sum);

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_err   = r_err;
        o_wr.en   = 1'b0;
        o_wr.addr = tail_slot;
        if (i_go) begin
            n_err = 1'b0;
            unique case (i_cmd)
                bdq_pkg::CMD_PUSH_FRONT: begin
                    if (full) begin
                        n_err = 1'b1;
                    end else begin
                        n_head    = head_dec;
                        n_count   = r_count + 1'b1;
                        o_wr.en   = 1'b1;
                        o_wr.addr = head_dec;
                    end
                end
                bdq_pkg::CMD_PUSH_REAR: begin
                    if (full) begin
                        n_err = 1'b1;
                    end else begin
                        n_count = r_count + 1'b1;
                        o_wr.en = 1'b1;
                    end
                end
                bdq_pkg::CMD_POP_FRONT: begin
                    if (empty) begin
                        n_err = 1'b1;
                    end else begin
                        n_head  = head_inc;
                        n_count = r_count - 1'b1;
                    end
                end
                bdq_pkg::CMD_POP_REAR: begin
                    if (empty) begin
                        n_err = 1'b1;
                    end else begin
                        n_count = r_count - 1'b1;
                    end
                end
                default: begin
                    // peek and unused codes: hold
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_err   <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_err   <= n_err;
        end
    end

    assign o_stat.head  = r_head;
    assign o_stat.rear  = rear_slot;
    assign o_stat.count = r_count;
    assign o_stat.err   = r_err;
    assign o_stat.empty = empty;
    assign o_stat.full  = full;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bdq_pkg::CW'(bdq_pkg::DEPTH))
        else $error("entry count above depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= bdq_pkg::AW'(bdq_pkg::DEPTH - 1))
        else $error("head pointer out of range");

    a_err_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && n_err) |=> (r_count == $past(r_count) && r_head == $past(r_head)))
        else $error("failed command changed the queue");

    a_no_write_on_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_wr.en && n_err))
        else $error("write issued on a failed push");

endmodule

`default_nettype wire

// ----- src/bounded_double_ended_queue.sv -----
// The entry memory is written when a command beat is accepted and read for
// front and rear in the read state that follows; the result is loaded from
// the done state, and no new command is accepted until it is loaded.
// A stalled result holds the next one in the done state, and so holds acceptance.
// Reset clears head pointer, count, error flag, sequencer and output valid; the entry
// memory is not cleared and needs no clearing pass.
`default_nettype none

module bounded_double_ended_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire bdq_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output bdq_pkg::t_out      o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic                       r_out_valid, n_out_valid;
    bdq_pkg::t_out              r_out, n_out;
    logic                       go;
    logic                       load;
    bdq_pkg::t_wr               wr;
    bdq_pkg::t_stat             stat;
    logic [bdq_pkg::WORD_W-1:0] front_word, rear_word;

    assign o_in_ready = (r_state == S_IDLE);
    assign go         = i_in_valid && o_in_ready;
    assign load       = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    bdq_ptr u_ptr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_cmd   (i_in_data.cmd),
        .o_wr    (wr),
        .o_stat  (stat)
    );

    // read follows the write edge, so a freshly pushed entry is seen
    bdq_ram u_ram (
        .i_clk     (i_clk),
        .i_we      (wr.en),
        .i_waddr   (wr.addr),
        .i_wdata   (i_in_data.value),
        .i_re      (r_state == S_READ),
        .i_raddr_a (stat.head),
        .i_raddr_b (stat.rear),
        .o_rdata_a (front_word),
        .o_rdata_b (rear_word)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (go) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (load) begin
            n_out_valid       = 1'b1;
            n_out.error       = stat.err;
            n_out.front_value = stat.empty ? bdq_pkg::EMPTY_WORD : front_word;
            n_out.rear_value  = stat.empty ? bdq_pkg::EMPTY_WORD : rear_word;
            n_out.is_empty    = stat.empty;
            n_out.is_full     = stat.full;
            n_out.occupancy   = bdq_pkg::OCC_W'(stat.count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_rise_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the done state");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.is_empty == (o_out_data.occupancy == '0)))
        else $error("empty flag disagrees with occupancy");

    a_accept_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |=> (r_state == S_READ))
        else $error("accepted beat not followed by memory read");

endmodule

`default_nettype wire
